FILE: design/llsf_pkg.sv
package llsf_pkg;

   // Point and set limits
   localparam int MAX_POINTS = 4096;
   localparam int PT_W       = 16;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int PC_W       = 13;
   localparam int FB_W       = 5;
   localparam int SHIFT_MAX  = (1 << FB_W) - 1;

   // Accumulator and product widths
   localparam int MAG_W      = 2 * PT_W + CNT_W;
   localparam int OPD_W      = MAG_W + 1;
   localparam int PRD_W      = 2 * MAG_W + 1;
   localparam int NUM_W      = PRD_W + 1;
   localparam int CHUNK_W    = 16;
   localparam int NCHUNK     = (MAG_W + CHUNK_W - 1) / CHUNK_W;
   localparam int CHK_W      = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

   // Divider widths
   localparam int DEN_W      = 64;
   localparam int DVD_W      = NUM_W + SHIFT_MAX;
   localparam int STEP_W     = $clog2(DVD_W + 1);
   localparam int RES_W      = 32;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ZERO_DEN = 2'd1,
      STATUS_DROPPED  = 2'd2
   } status_type;

   // One finished set of sums handed from front to back
   typedef struct packed {
      logic [CNT_W-1:0]        count;
      logic signed [OPD_W-1:0] sum_x;
      logic signed [OPD_W-1:0] sum_y;
      logic signed [OPD_W-1:0] sum_xy;
      logic signed [OPD_W-1:0] sum_xx;
      logic                    overflowed;
   } sums_type;

   // Queue status toward the front and back
   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

FILE: design/linear_least_squares_fit.sv
// Channel   Direction  Handshake          Payload
// req_      in         valid / stall      x_value, y_value, last_point
// rsp_      out        valid / stall      slope, intercept, point_count, status
// csr_      in         write_enable       write_data (fraction_bits)
//
// Points are taken one per cycle; only a full two-entry set queue stalls req_.
// A set then goes through the back end: the pop, six products (each started, worked in
// three 16-bit chunks and done), the two parallel 123-step dividers, then the result.
// A zero denominator skips the dividers.
// A waiting result beat holds its register while the next set is worked on.
// Reset is synchronous; fraction_bits returns to 8 and all sums clear.
module linear_least_squares_fit import llsf_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [PT_W-1:0]  req_x_value,
   input  logic signed [PT_W-1:0]  req_y_value,
   input  logic                    req_last_point,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [RES_W-1:0] rsp_slope,
   output logic signed [RES_W-1:0] rsp_intercept,
   output logic [PC_W-1:0]         rsp_point_count,
   output logic [1:0]              rsp_status,
   input  logic                    csr_write_enable,
   input  logic [FB_W-1:0]         csr_write_data
);

   logic [FB_W-1:0]  fb_ff;
   logic             push, pop;
   sums_type         push_data, head;
   queue_status_type q_status;

   // Fraction bits register
   always_ff @(posedge clock) begin
      if (reset)
         fb_ff <= FB_W'(8);
      else if (csr_write_enable)
         fb_ff <= csr_write_data;
   end

   llsf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_x_value    (req_x_value),
      .req_y_value    (req_y_value),
      .req_last_point (req_last_point),
      .q_status       (q_status),
      .push           (push),
      .push_data      (push_data)
   );

   llsf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   llsf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .fraction_bits   (fb_ff),
      .q_status        (q_status),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_slope       (rsp_slope),
      .rsp_intercept   (rsp_intercept),
      .rsp_point_count (rsp_point_count),
      .rsp_status      (rsp_status)
   );

endmodule

FILE: design/llsf_front.sv
module llsf_front import llsf_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [PT_W-1:0]  req_x_value,
   input  logic signed [PT_W-1:0]  req_y_value,
   input  logic                    req_last_point,
   input  queue_status_type        q_status,
   output logic                    push,
   output sums_type                push_data
);

   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [OPD_W-1:0] sum_x_ff, sum_x_in;
   logic signed [OPD_W-1:0] sum_y_ff, sum_y_in;
   logic signed [OPD_W-1:0] sum_xy_ff, sum_xy_in;
   logic signed [OPD_W-1:0] sum_xx_ff, sum_xx_in;
   logic                    ovf_ff, ovf_in;
   logic signed [2*PT_W-1:0] xy, xx;
   logic                    accept;

   assign req_stall = q_status.full;
   assign accept    = req_valid & ~q_status.full;
   assign xy        = req_x_value * req_y_value;
   assign xx        = req_x_value * req_x_value;

   // Add the point unless the set is already full
   always_comb begin
      count_in  = count_ff;
      sum_x_in  = sum_x_ff;
      sum_y_in  = sum_y_ff;
      sum_xy_in = sum_xy_ff;
      sum_xx_in = sum_xx_ff;
      ovf_in    = ovf_ff;
      if (count_ff < CNT_W'(MAX_POINTS)) begin
         count_in  = count_ff + 1'b1;
         sum_x_in  = sum_x_ff + OPD_W'(req_x_value);
         sum_y_in  = sum_y_ff + OPD_W'(req_y_value);
         sum_xy_in = sum_xy_ff + OPD_W'(xy);
         sum_xx_in = sum_xx_ff + OPD_W'(xx);
      end else begin
         ovf_in = 1'b1;
      end
   end

   assign push                 = accept & req_last_point;
   assign push_data.count      = count_in;
   assign push_data.sum_x      = sum_x_in;
   assign push_data.sum_y      = sum_y_in;
   assign push_data.sum_xy     = sum_xy_in;
   assign push_data.sum_xx     = sum_xx_in;
   assign push_data.overflowed = ovf_in;

   // Accumulators clear after the last point of a set
   always_ff @(posedge clock) begin
      if (reset || push) begin
         count_ff  <= '0;
         sum_x_ff  <= '0;
         sum_y_ff  <= '0;
         sum_xy_ff <= '0;
         sum_xx_ff <= '0;
         ovf_ff    <= 1'b0;
      end else if (accept) begin
         count_ff  <= count_in;
         sum_x_ff  <= sum_x_in;
         sum_y_ff  <= sum_y_in;
         sum_xy_ff <= sum_xy_in;
         sum_xx_ff <= sum_xx_in;
         ovf_ff    <= ovf_in;
      end
   end

endmodule

FILE: design/llsf_queue.sv
module llsf_queue import llsf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sums_type         push_data,
   input  logic             pop,
   output sums_type         head,
   output queue_status_type status
);

   sums_type   entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] fill_ff;

   assign head             = entry_ff[rd_ptr_ff];
   assign status.full      = (fill_ff == 2'd2);
   assign status.not_empty = (fill_ff != 2'd0);

   // Two-entry ring of finished sets
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push)
            wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)
            rd_ptr_ff <= ~rd_ptr_ff;
         if (push && !pop)
            fill_ff <= fill_ff + 2'd1;
         else if (pop && !push)
            fill_ff <= fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

FILE: design/llsf_mult.sv
module llsf_mult import llsf_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [OPD_W-1:0] opd_a,
   input  logic signed [OPD_W-1:0] opd_b,
   output logic                    done,
   output logic signed [PRD_W-1:0] product
);

   logic [MAG_W-1:0]            ma_ff;
   logic [NCHUNK*CHUNK_W-1:0]   mb_ff;
   logic                        neg_ff;
   logic [2*MAG_W-1:0]          acc_ff, acc_in;
   logic [CHK_W-1:0]            idx_ff;
   logic                        busy_ff, done_ff;
   logic [MAG_W+CHUNK_W-1:0]    partial;
   logic signed [PRD_W-1:0]     product_ff;
   logic signed [OPD_W-1:0]     abs_a, abs_b;

   assign abs_a   = opd_a[OPD_W-1] ? -opd_a : opd_a;
   assign abs_b   = opd_b[OPD_W-1] ? -opd_b : opd_b;
   assign partial = ma_ff * mb_ff[CHUNK_W-1:0];
   assign acc_in  = acc_ff + ((2*MAG_W)'(partial) << (idx_ff * CHUNK_W));
   assign done    = done_ff;
   assign product = product_ff;

   // One 16-bit chunk of the second operand per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (busy_ff) begin
            if (idx_ff == CHK_W'(NCHUNK - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ma_ff  <= MAG_W'(abs_a);
         mb_ff  <= (NCHUNK*CHUNK_W)'(MAG_W'(abs_b));
         neg_ff <= opd_a[OPD_W-1] ^ opd_b[OPD_W-1];
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         mb_ff  <= mb_ff >> CHUNK_W;
         if (neg_ff)
            product_ff <= -$signed({1'b0, acc_in});
         else
            product_ff <= $signed({1'b0, acc_in});
      end
   end

endmodule

FILE: design/llsf_div.sv
module llsf_div import llsf_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DVD_W-1:0]        dividend,
   input  logic                    negative,
   input  logic [DEN_W-1:0]        divisor,
   output logic                    done,
   output logic signed [RES_W-1:0] quotient
);

   logic [DVD_W-1:0]  dvd_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [DEN_W:0]    rem_sh;
   logic              ge;
   logic [RES_W:0]    q_ff;
   logic              big_ff, neg_ff, busy_ff, done_ff;
   logic [STEP_W-1:0] step_ff;
   logic              sat;

   assign rem_sh = {rem_ff, dvd_ff[DVD_W-1]};
   assign ge     = (rem_sh >= {1'b0, den_ff});
   assign done   = done_ff;

   // Saturate the magnitude to signed 32 bits
   always_comb begin
      if (neg_ff) begin
         sat = big_ff | q_ff[RES_W] | q_ff[RES_W-1];
         if (sat && q_ff[RES_W-1:0] != {1'b1, {(RES_W-1){1'b0}}} || sat && (big_ff || q_ff[RES_W]))
            quotient = $signed({1'b1, {(RES_W-1){1'b0}}});
         else
            quotient = -$signed(q_ff[RES_W-1:0]);
      end else begin
         sat = big_ff | q_ff[RES_W] | q_ff[RES_W-1];
         if (sat)
            quotient = $signed({1'b0, {(RES_W-1){1'b1}}});
         else
            quotient = $signed(q_ff[RES_W-1:0]);
      end
   end

   // Restoring division, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(DVD_W);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         den_ff <= divisor;
         neg_ff <= negative;
         rem_ff <= '0;
         q_ff   <= '0;
         big_ff <= 1'b0;
      end else if (busy_ff) begin
         dvd_ff <= dvd_ff << 1;
         rem_ff <= ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : DEN_W'(rem_sh);
         q_ff   <= {q_ff[RES_W-1:0], ge};
         big_ff <= big_ff | q_ff[RES_W];
      end
   end

endmodule

FILE: design/llsf_back.sv
module llsf_back import llsf_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [FB_W-1:0]         fraction_bits,
   input  queue_status_type        q_status,
   input  sums_type                head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [RES_W-1:0] rsp_slope,
   output logic signed [RES_W-1:0] rsp_intercept,
   output logic [PC_W-1:0]         rsp_point_count,
   output logic [1:0]              rsp_status
);

   localparam logic [2:0] K_LAST = 3'd5;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MUL  = 4'b0010,
      S_DIV  = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type               state_ff;
   sums_type                snap_ff;
   logic [2:0]              k_ff;
   logic                    mul_start_ff, div_start_ff;
   logic signed [OPD_W-1:0] opd_a, opd_b, n_opd;
   logic                    mul_done;
   logic signed [PRD_W-1:0] product;
   logic signed [PRD_W-1:0] part_ff;
   logic signed [NUM_W-1:0] diff;
   logic signed [NUM_W-1:0] den_ff, snum_ff, inum_ff;
   logic                    den_bad;
   logic [NUM_W-1:0]        snum_mag, inum_mag;
   logic                    sdone, idone;
   logic signed [RES_W-1:0] sq, iq;
   logic signed [RES_W-1:0] slope_ff, icpt_ff, slope_res_ff, icpt_res_ff;
   logic [PC_W-1:0]         pc_ff, pc_res_ff;
   status_type              status_ff, status_res_ff;
   logic                    rsp_valid_ff;

   assign n_opd = OPD_W'(snap_ff.count);

   // Operand pairs of the six products
   always_comb begin
      case (k_ff)
         3'd0: begin opd_a = n_opd;          opd_b = snap_ff.sum_xx; end
         3'd1: begin opd_a = snap_ff.sum_x;  opd_b = snap_ff.sum_x;  end
         3'd2: begin opd_a = n_opd;          opd_b = snap_ff.sum_xy; end
         3'd3: begin opd_a = snap_ff.sum_x;  opd_b = snap_ff.sum_y;  end
         3'd4: begin opd_a = snap_ff.sum_y;  opd_b = snap_ff.sum_xx; end
         default: begin opd_a = snap_ff.sum_x; opd_b = snap_ff.sum_xy; end
      endcase
   end

   llsf_mult u_mult (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .opd_a   (opd_a),
      .opd_b   (opd_b),
      .done    (mul_done),
      .product (product)
   );

   assign diff     = NUM_W'(part_ff) - NUM_W'(product);
   assign den_bad  = (den_ff[NUM_W-1:DEN_W] != '0) || (den_ff[DEN_W-1:0] == '0);
   assign snum_mag = snum_ff[NUM_W-1] ? NUM_W'(-snum_ff) : NUM_W'(snum_ff);
   assign inum_mag = inum_ff[NUM_W-1] ? NUM_W'(-inum_ff) : NUM_W'(inum_ff);

   llsf_div u_div_slope (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (DVD_W'(snum_mag) << fraction_bits),
      .negative (snum_ff[NUM_W-1]),
      .divisor  (den_ff[DEN_W-1:0]),
      .done     (sdone),
      .quotient (sq)
   );

   llsf_div u_div_icpt (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (DVD_W'(inum_mag) << fraction_bits),
      .negative (inum_ff[NUM_W-1]),
      .divisor  (den_ff[DEN_W-1:0]),
      .done     (idone),
      .quotient (iq)
   );

   assign pop = (state_ff == S_IDLE) && q_status.not_empty;

   // Sequencer: six products, then two divisions unless the denominator is bad, then the result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= '0;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         if (rsp_valid_ff && !rsp_stall)
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (q_status.not_empty) begin
                  k_ff         <= '0;
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_MUL;
               end
            end
            S_MUL: begin
               if (mul_done) begin
                  if (k_ff == K_LAST) begin
                     if (den_bad) begin
                        state_ff <= S_OUT;
                     end else begin
                        div_start_ff <= 1'b1;
                        state_ff     <= S_DIV;
                     end
                  end else begin
                     k_ff         <= k_ff + 3'd1;
                     mul_start_ff <= 1'b1;
                  end
               end
            end
            S_DIV: begin
               if (sdone && idone)
                  state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (pop)
         snap_ff <= head;
      if (state_ff == S_MUL && mul_done) begin
         if (!k_ff[0])
            part_ff <= product;
         else if (k_ff == 3'd1)
            den_ff <= diff;
         else if (k_ff == 3'd3)
            snum_ff <= diff;
         else
            inum_ff <= diff;
      end
      if (state_ff == S_MUL && mul_done && k_ff == K_LAST) begin
         pc_ff <= PC_W'(snap_ff.count);
      end
      if (state_ff == S_DIV && sdone && idone) begin
         slope_ff  <= sq;
         icpt_ff   <= iq;
         status_ff <= snap_ff.overflowed ? STATUS_DROPPED : STATUS_OK;
      end
      if (state_ff == S_MUL && mul_done && k_ff == K_LAST && den_bad) begin
         slope_ff  <= '0;
         icpt_ff   <= '0;
         status_ff <= STATUS_ZERO_DEN;
      end
      if (state_ff == S_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         slope_res_ff  <= slope_ff;
         icpt_res_ff   <= icpt_ff;
         status_res_ff <= status_ff;
         pc_res_ff     <= pc_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slope       = slope_res_ff;
   assign rsp_intercept   = icpt_res_ff;
   assign rsp_point_count = pc_res_ff;
   assign rsp_status      = status_res_ff;

endmodule
